// ===== rtl/core/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the power trend congestion window control.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int WIN_W     = 32;
	localparam int SEG_W     = 16;
	localparam int DRAW_W    = 4;
	localparam int ACT_W     = 2;
	localparam int ACK_W     = 2;
	localparam int DLT_W     = WIN_W + SEG_W;
	localparam int SER_STEPS = WIN_W;
	localparam int CNT_W     = $clog2(SER_STEPS);

	localparam logic [SEG_W-1:0]  SEG_RESET   = 16'd536;
	localparam logic [SEG_W-1:0]  STEP_DIV    = 16'd5;
	localparam logic [DRAW_W-1:0] EXPLORE_MAX = 4'd8;
	localparam logic [ACK_W-1:0]  ACKS_FULL   = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE = 2'd0,
		ACT_INC  = 2'd1,
		ACT_DEC  = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SEG,
		S_LD2,
		S_STP,
		S_LD3,
		S_DLT,
		S_FIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} unit_ctl_t;

endpackage

// ===== rtl/core/ptc_div.sv =====
// ----------------------------------------------------------------------------
// ptc_div
// Bit-serial restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module ptc_div
	import ptc_pkg::*;
(
	input  logic             clk,
	input  unit_ctl_t        ctl,
	input  logic [WIN_W-1:0] dividend,
	input  logic [SEG_W-1:0] divisor,
	output logic [WIN_W-1:0] quotient
);

	logic [WIN_W-1:0] q_q;
	logic [SEG_W-1:0] r_q;
	logic [SEG_W-1:0] d_q;
	logic [SEG_W:0]   trial;
	logic [SEG_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {r_q, q_q[WIN_W-1]};
		diff  = trial - {1'b0, d_q};
		fits  = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (ctl.step) begin
			q_q <= {q_q[WIN_W-2:0], fits};
			r_q <= fits ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
		end
	end

	assign quotient = q_q;

endmodule

// ===== rtl/core/ptc_mul.sv =====
// ----------------------------------------------------------------------------
// ptc_mul
// Shift-add multiplier, one multiplier bit per step, B_W steps per product.
// ----------------------------------------------------------------------------
module ptc_mul
	import ptc_pkg::*;
#(
	parameter int A_W = 48,
	parameter int B_W = 32
) (
	input  logic               clk,
	input  unit_ctl_t          ctl,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] prod
);

	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] p_q;
	logic [A_W:0]       sum;

	always_comb begin
		sum = {1'b0, p_q[A_W+B_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a;
			p_q <= {{A_W{1'b0}}, b};
		end else if (ctl.step) begin
			p_q <= {sum, p_q[B_W-1:1]};
		end
	end

	assign prod = p_q;

endmodule

// ===== rtl/core/power_trend_cwnd_control.sv =====
// ----------------------------------------------------------------------------
// power_trend_cwnd_control
// Power trend congestion window control: per ACK word, keep the window until
// the deadline, else grow or shrink it a fifth on the trend of segments/rtt^2.
// ----------------------------------------------------------------------------
// Words: one at a time; in_stall is low only in idle, until a word is taken.
// Rounds: the serial divider and the two shift-add multipliers take 32 steps
//   per round; all three step in rounds one and two, only one multiplier in
//   the third. Reset: arst_n clears control, deadline and prior segments,
//   sets prior rtt to all ones and segment size to 536.
module power_trend_cwnd_control
	import ptc_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int RTT_BITS  = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SEG_W-1:0]     segment_bytes,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WIN_W-1:0]     window_bytes,
	input  logic [RTT_BITS-1:0]  rtt_us,
	input  logic [TIME_BITS-1:0] now_us,
	input  logic [DRAW_W-1:0]    explore_draw,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WIN_W-1:0]     new_window_bytes,
	output logic [ACT_W-1:0]     action
);

	localparam int SQ_W   = 2 * RTT_BITS;
	localparam int PROD_W = SQ_W + WIN_W;

	state_t state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [SEG_W-1:0]     sb_q;
	logic [ACK_W-1:0]     ack_q;
	logic [TIME_BITS-1:0] dl_q;
	logic                 dl_valid_q;
	logic [WIN_W-1:0]     prior_seg_q;
	logic [RTT_BITS-1:0]  prior_rtt_q;
	logic [WIN_W-1:0]     win_q;
	logic [RTT_BITS-1:0]  rtt_q;
	logic [TIME_BITS-1:0] now_q;
	logic [DRAW_W-1:0]    draw_q;
	logic [WIN_W-1:0]     seg_q;
	logic                 rose_q;
	logic [WIN_W-1:0]     res_win_q;
	action_t              res_act_q;
	logic                 out_valid_q;
	logic [WIN_W-1:0]     out_win_q;
	action_t              out_act_q;

	logic [SEG_W-1:0]  sbx;
	logic              upd;
	logic              last;
	logic              out_free;
	logic              in_acc;
	unit_ctl_t         div_ctl, mul0_ctl, mul1_ctl;
	logic [WIN_W-1:0]  div_num;
	logic [SEG_W-1:0]  div_den;
	logic [WIN_W-1:0]  quo;
	logic [SQ_W-1:0]   mul0_a, mul1_a;
	logic [WIN_W-1:0]  mul0_b, mul1_b;
	logic [PROD_W-1:0] prod0, prod1;
	logic [DLT_W-1:0]  delta;
	logic [DLT_W:0]    sum;
	logic [DLT_W-1:0]  diff;
	logic              grow;
	logic [WIN_W-1:0]  fin_win;
	action_t           fin_act;

	assign sbx      = (sb_q == '0) ? SEG_W'(1) : sb_q;
	assign upd      = !dl_valid_q || (dl_q < now_q);
	assign last     = cnt_q == CNT_W'(SER_STEPS - 1);
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_CHECK;
			S_CHECK: state_d = upd ? S_SEG : S_EMIT;
			S_SEG:   if (last) state_d = S_LD2;
			S_LD2:   state_d = S_STP;
			S_STP:   if (last) state_d = S_LD3;
			S_LD3:   state_d = S_DLT;
			S_DLT:   if (last) state_d = S_FIN;
			S_FIN:   state_d = S_EMIT;
			S_EMIT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall      = 1'b1;
		cfg_ready     = 1'b0;
		div_ctl       = '0;
		mul0_ctl      = '0;
		mul1_ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			S_CHECK: begin
				div_ctl.load  = upd;
				mul0_ctl.load = upd;
				mul1_ctl.load = upd;
			end
			S_SEG, S_STP: begin
				div_ctl.step  = 1'b1;
				mul0_ctl.step = 1'b1;
				mul1_ctl.step = 1'b1;
			end
			S_LD2: begin
				div_ctl.load  = 1'b1;
				mul0_ctl.load = 1'b1;
				mul1_ctl.load = 1'b1;
			end
			S_LD3:   mul0_ctl.load = 1'b1;
			S_DLT:   mul0_ctl.step = 1'b1;
			default: ;
		endcase
	end

	// operand selection
	always_comb begin
		div_num = win_q;
		div_den = sbx;
		mul0_a  = SQ_W'(prior_rtt_q);
		mul0_b  = WIN_W'(prior_rtt_q);
		mul1_a  = SQ_W'(rtt_q);
		mul1_b  = WIN_W'(rtt_q);
		unique case (state_q)
			S_LD2: begin
				div_num = quo;
				div_den = STEP_DIV;
				mul0_a  = prod0[SQ_W-1:0];
				mul0_b  = quo;
				mul1_a  = prod1[SQ_W-1:0];
				mul1_b  = prior_seg_q;
			end
			S_LD3: begin
				mul0_a = SQ_W'((quo == '0) ? WIN_W'(1) : quo);
				mul0_b = WIN_W'(sbx);
			end
			default: ;
		endcase
	end

	ptc_div u_div (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quo)
	);

	ptc_mul #(
		.A_W (SQ_W),
		.B_W (WIN_W)
	) u_mul0 (
		.clk  (clk),
		.ctl  (mul0_ctl),
		.a    (mul0_a),
		.b    (mul0_b),
		.prod (prod0)
	);

	ptc_mul #(
		.A_W (SQ_W),
		.B_W (WIN_W)
	) u_mul1 (
		.clk  (clk),
		.ctl  (mul1_ctl),
		.a    (mul1_a),
		.b    (mul1_b),
		.prod (prod1)
	);

	// window update
	always_comb begin
		delta = prod0[DLT_W-1:0];
		sum   = {1'b0, DLT_W'(win_q)} + {1'b0, delta};
		diff  = DLT_W'(win_q) - delta;
		grow  = rose_q && (draw_q <= EXPLORE_MAX);
		if (grow) begin
			fin_act = ACT_INC;
			fin_win = (sum[DLT_W:WIN_W] != '0) ? '1 : sum[WIN_W-1:0];
		end else begin
			fin_act = ACT_DEC;
			if ((delta > DLT_W'(win_q)) || (diff < DLT_W'(sbx)))
				fin_win = WIN_W'(sbx);
			else
				fin_win = diff[WIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sb_q        <= SEG_RESET;
			ack_q       <= '0;
			dl_q        <= '0;
			dl_valid_q  <= 1'b0;
			prior_seg_q <= '0;
			prior_rtt_q <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SEG || state_q == S_STP || state_q == S_DLT)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
			if (cfg_valid && cfg_ready)
				sb_q <= segment_bytes;
			if (in_acc && ack_q != ACKS_FULL)
				ack_q <= ack_q + ACK_W'(1);
			if (state_q == S_FIN) begin
				dl_q        <= now_q + TIME_BITS'({rtt_q, 1'b0});
				dl_valid_q  <= 1'b1;
				prior_seg_q <= seg_q;
				prior_rtt_q <= rtt_q;
			end
			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_q  <= window_bytes;
			rtt_q  <= (rtt_us == '0) ? RTT_BITS'(1) : rtt_us;
			now_q  <= now_us;
			draw_q <= explore_draw;
		end
		if (state_q == S_CHECK && !upd) begin
			res_win_q <= win_q;
			res_act_q <= ACT_NONE;
		end
		if (state_q == S_LD2)
			seg_q <= quo;
		if (state_q == S_LD3)
			rose_q <= (ack_q == ACKS_FULL) && (prior_seg_q != '0) && (prod0 > prod1);
		if (state_q == S_FIN) begin
			res_win_q <= fin_win;
			res_act_q <= fin_act;
		end
		if (state_q == S_EMIT && out_free) begin
			out_win_q <= res_win_q;
			out_act_q <= res_act_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign new_window_bytes = out_win_q;
	assign action           = out_act_q;

endmodule

// ===== rtl/core/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the power trend congestion window control.
// ----------------------------------------------------------------------------
module ptc_checker
	import ptc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_ready,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [WIN_W-1:0] new_window_bytes,
	input logic [ACT_W-1:0] action
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_window_bytes) && $stable(action))
		else $error("stalled output word changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready != in_stall)
		else $error("config ready outside idle");

	a_update_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_INC || action == ACT_DEC) |-> new_window_bytes != '0)
		else $error("updated window is zero");

endmodule

bind power_trend_cwnd_control ptc_checker u_ptc_checker (.*);

// ===== dv/power_trend_cwnd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_trend_cwnd_checker
// Passive checker for the power trend window control. Watches the config,
// ACK and result channels, predicts each result word from its own copy of
// the segment size, deadline and power history, and compares in order.
// ----------------------------------------------------------------------------
module power_trend_cwnd_checker
	import ptc_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int RTT_BITS  = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [SEG_W-1:0]     segment_bytes,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [WIN_W-1:0]     window_bytes,
	input  logic [RTT_BITS-1:0]  rtt_us,
	input  logic [TIME_BITS-1:0] now_us,
	input  logic [DRAW_W-1:0]    explore_draw,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [WIN_W-1:0]     new_window_bytes,
	input  logic [ACT_W-1:0]     action,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [WIN_W-1:0] win;
		action_t          act;
	} cwnd_word_t;

	cwnd_word_t expected_words[$];
	cwnd_word_t head, res;

	logic [SEG_W-1:0]     seg_size;
	logic [WIN_W-1:0]     prior_segs;
	logic [RTT_BITS-1:0]  prior_rtt;
	logic [TIME_BITS-1:0] deadline;
	logic                 deadline_set;
	logic [ACK_W-1:0]     acks;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic step_window(
		input  logic [WIN_W-1:0]     win,
		input  logic [RTT_BITS-1:0]  rtt_raw,
		input  logic [TIME_BITS-1:0] now,
		input  logic [DRAW_W-1:0]    draw,
		output cwnd_word_t           word
	);
		logic [RTT_BITS-1:0]           rtt;
		logic [WIN_W-1:0]              sb, segs, step;
		logic [DLT_W-1:0]              delta;
		logic [DLT_W:0]                grown;
		logic [2*RTT_BITS+WIN_W-1:0]   lhs, rhs;
		logic                          rose;
		rtt = (rtt_raw == '0) ? RTT_BITS'(1) : rtt_raw;
		if (acks < ACKS_FULL)
			acks = acks + 1'b1;
		if (deadline_set && !(deadline < now)) begin
			word.win = win;
			word.act = ACT_NONE;
		end else begin
			sb    = (seg_size == '0) ? WIN_W'(1) : WIN_W'(seg_size);
			segs  = win / sb;
			step  = segs / WIN_W'(STEP_DIV);
			if (step == '0)
				step = WIN_W'(1);
			delta = DLT_W'(step) * DLT_W'(sb);
			lhs   = $bits(lhs)'(segs) * $bits(lhs)'(prior_rtt) * $bits(lhs)'(prior_rtt);
			rhs   = $bits(rhs)'(prior_segs) * $bits(rhs)'(rtt) * $bits(rhs)'(rtt);
			rose  = (acks >= ACKS_FULL) && (prior_segs != '0) && (lhs > rhs);
			if (rose && draw <= EXPLORE_MAX) begin
				grown    = $bits(grown)'(win) + $bits(grown)'(delta);
				word.win = (grown > $bits(grown)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
					: grown[WIN_W-1:0];
				word.act = ACT_INC;
			end else begin
				if (delta > DLT_W'(win) || (DLT_W'(win) - delta) < DLT_W'(sb))
					word.win = sb;
				else
					word.win = win - delta[WIN_W-1:0];
				word.act = ACT_DEC;
			end
			deadline     = now + TIME_BITS'(rtt) + TIME_BITS'(rtt);
			deadline_set = 1'b1;
			prior_segs   = segs;
			prior_rtt    = rtt;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_size     = SEG_RESET;
			prior_segs   = '0;
			prior_rtt    = '1;
			deadline     = '0;
			deadline_set = 1'b0;
			acks         = '0;
			expected_words.delete();
			pending      = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				seg_size = segment_bytes;
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					flag_mismatch($sformatf("unexpected word win=%h action=%0d",
						new_window_bytes, action));
				end else begin
					head = expected_words.pop_front();
					if (new_window_bytes !== head.win)
						flag_mismatch($sformatf("new_window_bytes got %h exp %h",
							new_window_bytes, head.win));
					if (action !== head.act)
						flag_mismatch($sformatf("action got %0d exp %0d",
							action, head.act));
				end
			end
			if (in_valid && !in_stall) begin
				step_window(window_bytes, rtt_us, now_us, explore_draw, res);
				expected_words.push_back(res);
			end
			pending = expected_words.size();
		end
	end

endmodule

// ===== dv/power_trend_cwnd_control_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_trend_cwnd_control_tb
// Top of the power trend window control bench: drives ACK words and segment
// size writes with random gaps and result stalls, runs directed corner words
// then random phases at several segment sizes, and gives the verdict.
// ----------------------------------------------------------------------------
module power_trend_cwnd_control_tb;
	import ptc_pkg::*;

	localparam int TIME_BITS    = 48;
	localparam int RTT_BITS     = 24;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASE_ITEMS  = 217;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [SEG_W-1:0]     segment_bytes;
	logic                 in_valid;
	logic                 in_stall;
	logic [WIN_W-1:0]     window_bytes;
	logic [RTT_BITS-1:0]  rtt_us;
	logic [TIME_BITS-1:0] now_us;
	logic [DRAW_W-1:0]    explore_draw;
	logic                 out_valid;
	logic                 out_stall;
	logic [WIN_W-1:0]     new_window_bytes;
	logic [ACT_W-1:0]     action;
	int                   errors;
	int                   pending;

	logic [SEG_W-1:0]     seg_now;
	logic [TIME_BITS-1:0] clock_us;
	logic [WIN_W-1:0]     last_win;
	logic                 no_idle;
	int                   words_sent;
	int                   idle_cycles;

	power_trend_cwnd_control #(
		.TIME_BITS (TIME_BITS),
		.RTT_BITS  (RTT_BITS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.segment_bytes    (segment_bytes),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.window_bytes     (window_bytes),
		.rtt_us           (rtt_us),
		.now_us           (now_us),
		.explore_draw     (explore_draw),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.new_window_bytes (new_window_bytes),
		.action           (action)
	);

	power_trend_cwnd_checker #(
		.TIME_BITS (TIME_BITS),
		.RTT_BITS  (RTT_BITS)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.segment_bytes    (segment_bytes),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.window_bytes     (window_bytes),
		.rtt_us           (rtt_us),
		.now_us           (now_us),
		.explore_draw     (explore_draw),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.new_window_bytes (new_window_bytes),
		.action           (action),
		.errors           (errors),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_win <= '0;
		else if (out_valid && !out_stall)
			last_win <= new_window_bytes;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side back-pressure, one draw per word
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			n = no_idle ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// entered and left at a falling edge
	task automatic send_ack(
		input logic [WIN_W-1:0]     win,
		input logic [RTT_BITS-1:0]  rtt,
		input logic [TIME_BITS-1:0] now,
		input logic [DRAW_W-1:0]    draw
	);
		int gap;
		words_sent++;
		if (words_sent % 48 == 0)
			no_idle = ($urandom_range(0, 3) == 0);
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		window_bytes <= win;
		rtt_us       <= rtt;
		now_us       <= now;
		explore_draw <= draw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_segment(input logic [SEG_W-1:0] value);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		@(negedge clk);
		cfg_valid     <= 1'b1;
		segment_bytes <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		seg_now = value;
	endtask

	task automatic run_random(input int count);
		logic [RTT_BITS-1:0] rtt;
		logic [WIN_W-1:0]    win;
		logic [DRAW_W-1:0]   draw;
		int unsigned         sb, base_rtt, pick;
		base_rtt = $urandom_range(1, 4000);
		sb = (seg_now == '0) ? 1 : seg_now;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				rtt = '0;
			else if (pick < 16)
				rtt = RTT_BITS'($urandom);
			else
				rtt = RTT_BITS'(base_rtt + $urandom_range(0, base_rtt / 8));
			pick = $urandom_range(0, 99);
			if (pick < 4)
				clock_us = TIME_BITS'({$urandom, $urandom});
			else
				clock_us = clock_us + TIME_BITS'($urandom_range(0, 4 * rtt + 8));
			pick = $urandom_range(0, 99);
			if (pick < 50)
				win = last_win;
			else if (pick < 80)
				win = sb * $urandom_range(0, 3000) + $urandom_range(0, sb - 1);
			else
				win = $urandom;
			draw = ($urandom_range(0, 6) == 0) ? DRAW_W'($urandom_range(0, 15))
				: DRAW_W'($urandom_range(0, 9));
			send_ack(win, rtt, clock_us, draw);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		segment_bytes = SEG_RESET;
		in_valid      = 1'b0;
		window_bytes  = '0;
		rtt_us        = '0;
		now_us        = '0;
		explore_draw  = '0;
		seg_now       = SEG_RESET;
		clock_us      = '0;
		no_idle       = 1'b0;
		words_sent    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners at the reset segment size
		send_ack(32'd0, 24'd0, 48'd0, 4'd0);
		send_ack(32'd0, 24'd0, 48'd0, 4'd0);
		send_ack(32'd100, 24'd0, 48'd3, 4'd0);
		send_ack(32'd53600, 24'd100, 48'd10, 4'd0);
		send_ack(32'd107200, 24'd100, 48'd300, 4'd3);
		send_ack(32'd160800, 24'd100, 48'd600, 4'd9);
		send_ack(32'd214400, 24'd100, 48'd900, 4'd15);
		send_ack(32'd268000, 24'd100, 48'd1200, 4'd8);
		send_ack(32'd268000, 24'd200, 48'd1500, 4'd0);
		send_ack(32'hFFFF_FFFF, 24'd1, 48'd2000, 4'd0);
		send_ack(32'hFFFF_FFFF, 24'd1, 48'd2003, 4'd0);
		send_ack(32'd636, 24'd1, 48'd2006, 4'd0);
		send_ack(32'hFFFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'd4);
		send_ack(32'h0000_1000, 24'd5, 48'd0, 4'd0);
		send_ack(32'h0000_1000, 24'd5, 48'd33554430, 4'd0);
		send_ack(32'h0000_1000, 24'd5, 48'd33554440, 4'd0);
		send_ack(32'h0000_2000, 24'd5, 48'd33554441, 4'd2);
		send_ack(32'h5555_5555, 24'hAA_AAAA, 48'h5555_5555_5555, 4'd5);
		send_ack(32'hAAAA_AAAA, 24'h55_5555, 48'hAAAA_AAAA_AAAA, 4'd10);
		clock_us = 48'hAAAA_AAAA_AAAA;

		write_segment(16'd1460);
		run_random(PHASE_ITEMS);
		write_segment(16'd1);
		run_random(PHASE_ITEMS);
		write_segment(16'hFFFF);
		run_random(PHASE_ITEMS);
		write_segment(16'd0);
		run_random(PHASE_ITEMS);
		write_segment(SEG_W'($urandom_range(1, 65535)));
		run_random(PHASE_ITEMS);
		write_segment(SEG_RESET);
		run_random(PHASE_ITEMS);

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ptc_pkg.sv
rtl/core/ptc_div.sv
rtl/core/ptc_mul.sv
rtl/core/power_trend_cwnd_control.sv
rtl/core/ptc_checker.sv
dv/power_trend_cwnd_checker.sv
dv/power_trend_cwnd_control_tb.sv
